[rtl/prc_pkg.sv]
package prc_pkg;

  localparam int NumEdges = 7;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [33:0] wide_t;

  // polygon vertices in hundredths of a degree, edge k runs from vertex k to k+1 (the last edge back to vertex 0)
  localparam coord_t VERT_LON [NumEdges] = '{
    -16'sd8800, -16'sd8800, -16'sd5500, -16'sd3200, -16'sd700, 16'sd5000, 16'sd5000
  };
  localparam coord_t VERT_LAT [NumEdges] = '{
    -16'sd3000, -16'sd1200, -16'sd10, -16'sd10, -16'sd1200, -16'sd2500, -16'sd3000
  };
  localparam coord_t EDGE_DX [NumEdges] = '{
    16'sd0, 16'sd3300, 16'sd2300, 16'sd2500, 16'sd5700, 16'sd0, -16'sd13800
  };
  localparam coord_t EDGE_DY [NumEdges] = '{
    16'sd1800, 16'sd1190, 16'sd0, -16'sd1190, -16'sd1300, -16'sd500, 16'sd0
  };
  localparam wide_t EDGE_LEN2 [NumEdges] = '{
    34'sd3240000, 34'sd12306100, 34'sd5290000, 34'sd7666100,
    34'sd34180000, 34'sd250000, 34'sd190440000
  };

  localparam logic signed [15:0] BoxLonMin = -16'sd8800;
  localparam logic signed [15:0] BoxLonMax = 16'sd5000;
  localparam logic signed [14:0] BoxLatMin = -15'sd3000;
  localparam logic signed [14:0] BoxLatMax = -15'sd10;

  // point travelling down the edge cells with its running verdict
  typedef struct packed {
    logic signed [15:0] longitude;
    logic signed [14:0] latitude;
    logic               in_box;
    logic               covered;
    logic               bad;
  } point_t;

endpackage

[rtl/prc_in_if.sv]
interface prc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] longitude;
  logic signed [14:0] latitude;

  modport source (output valid, output longitude, output latitude, input ready);
  modport sink (input valid, input longitude, input latitude, output ready);
endinterface

[rtl/prc_out_if.sv]
interface prc_out_if;
  logic valid;
  logic ready;
  logic inside_region;

  modport source (output valid, output inside_region, input ready);
  modport sink (input valid, input inside_region, output ready);
endinterface

[rtl/prc_cell.sv]
module prc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  prc_pkg::point_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output prc_pkg::point_t out_data,
  input  prc_pkg::coord_t vx,
  input  prc_pkg::coord_t vy,
  input  prc_pkg::coord_t dx,
  input  prc_pkg::coord_t dy,
  input  prc_pkg::wide_t  len2
);

  logic signed [16:0] ox;
  logic signed [16:0] oy;
  prc_pkg::wide_t     dot;
  prc_pkg::wide_t     cross_prod;
  logic               cov;
  prc_pkg::point_t    data_next;
  logic               valid;
  prc_pkg::point_t    data;

  assign ox         = 17'(in_data.longitude) - 17'(vx);
  assign oy         = 17'(in_data.latitude) - 17'(vy);
  assign dot        = 34'(ox) * 34'(dx) + 34'(oy) * 34'(dy);
  assign cross_prod = 34'(oy) * 34'(dx) - 34'(ox) * 34'(dy);
  assign cov        = (dot >= 34'sd0) && (dot <= len2);

  always_comb begin
    data_next         = in_data;
    data_next.covered = in_data.covered | cov;
    // a covering edge must see the point on its negative side
    data_next.bad     = in_data.bad | (cov & ~cross_prod[33]);
  end

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

[rtl/polygon_region_test.sv]
// channel  dir  payload
// req      in   longitude[15:0] signed, latitude[14:0] signed
// rsp      out  inside_region
//
// one point per cycle while rsp is ready; each result passes through a register in
// every polygon edge cell of the chain.
// each cell holds its own item and stalls only when it is full and the cell
// after it cannot take, so bubbles close up under back pressure.
// synchronous reset empties the chain; the data registers are not reset.
module polygon_region_test (
  input logic   clk,
  input logic   rst,
  prc_in_if.sink    req,
  prc_out_if.source rsp
);

  logic            valid_c [prc_pkg::NumEdges+1];
  logic            ready_c [prc_pkg::NumEdges+1];
  prc_pkg::point_t data_c  [prc_pkg::NumEdges+1];

  always_comb begin
    data_c[0].longitude = req.longitude;
    data_c[0].latitude  = req.latitude;
    data_c[0].in_box    = (req.longitude >= prc_pkg::BoxLonMin) &&
                          (req.longitude <= prc_pkg::BoxLonMax) &&
                          (req.latitude >= prc_pkg::BoxLatMin) &&
                          (req.latitude <= prc_pkg::BoxLatMax);
    data_c[0].covered   = 1'b0;
    data_c[0].bad       = 1'b0;
  end

  assign valid_c[0] = req.valid;
  assign req.ready  = ready_c[0];

  for (genvar k = 0; k < prc_pkg::NumEdges; k++) begin : g_cell
    prc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[k]),
      .in_ready  (ready_c[k]),
      .in_data   (data_c[k]),
      .out_valid (valid_c[k+1]),
      .out_ready (ready_c[k+1]),
      .out_data  (data_c[k+1]),
      .vx        (prc_pkg::VERT_LON[k]),
      .vy        (prc_pkg::VERT_LAT[k]),
      .dx        (prc_pkg::EDGE_DX[k]),
      .dy        (prc_pkg::EDGE_DY[k]),
      .len2      (prc_pkg::EDGE_LEN2[k])
    );
  end

  assign rsp.valid                  = valid_c[prc_pkg::NumEdges];
  assign ready_c[prc_pkg::NumEdges] = rsp.ready;
  assign rsp.inside_region = data_c[prc_pkg::NumEdges].in_box &
                             data_c[prc_pkg::NumEdges].covered &
                             ~data_c[prc_pkg::NumEdges].bad;

endmodule
